// ===== rtl/swm_pkg.sv =====
// Package for the sliding window minimum block: widths, defaults and shared types.
`timescale 1ns / 1ps
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 11;
  localparam int WINDOW_MAX_DEF = 1024;

  // One result handed from the sequencer to the output register.
  typedef struct packed {
    logic                     load;
    logic signed [DATA_W-1:0] value;
  } swm_res_t;

endpackage

// ===== rtl/swm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/swm_out.sv =====
// Output register for result beats.
`timescale 1ns / 1ps
module swm_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  swm_pkg::swm_res_t                res,
  output logic                             res_ready,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [swm_pkg::DATA_W-1:0]       out_tdata
);
  import swm_pkg::*;

  logic              valid_r;
  logic [DATA_W-1:0] data_r;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res.load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.load) begin
      data_r <= res.value;
    end
  end

endmodule

// ===== rtl/swm_seq.sv =====
// Heap sequencer: insert, report and remove by read-modify-write on the heap memories.
`timescale 1ns / 1ps
module swm_seq #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [swm_pkg::DATA_W-1:0]      in_sample,
  input  logic                                   in_start,
  input  logic                                   cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]              cfg_data,
  output logic                                   h_we,
  output logic [$clog2(WINDOW_MAX)-1:0]          h_waddr,
  output logic [swm_pkg::DATA_W+$clog2(WINDOW_MAX)-1:0] h_wdata,
  output logic                                   h_re,
  output logic [$clog2(WINDOW_MAX)-1:0]          h_raddr,
  input  logic [swm_pkg::DATA_W+$clog2(WINDOW_MAX)-1:0] h_rdata,
  output logic                                   p_we,
  output logic [$clog2(WINDOW_MAX)-1:0]          p_waddr,
  output logic [$clog2(WINDOW_MAX)-1:0]          p_wdata,
  output logic                                   p_re,
  output logic [$clog2(WINDOW_MAX)-1:0]          p_raddr,
  input  logic [$clog2(WINDOW_MAX)-1:0]          p_rdata,
  output swm_pkg::swm_res_t                      res,
  input  logic                                   res_ready
);
  import swm_pkg::*;

  localparam int SW  = $clog2(WINDOW_MAX);
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int CXW = CW + 1;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_UP_CHK  = 13'b0000000000010,
    S_UP_CMP  = 13'b0000000000100,
    S_DN_CHK  = 13'b0000000001000,
    S_DN_L    = 13'b0000000010000,
    S_DN_R    = 13'b0000000100000,
    S_DN_CMP  = 13'b0000001000000,
    S_FIN     = 13'b0000010000000,
    S_TOP_RD  = 13'b0000100000000,
    S_TOP_CAP = 13'b0001000000000,
    S_RM_RD   = 13'b0010000000000,
    S_RM_LAST = 13'b0100000000000,
    S_RM_GET  = 13'b1000000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         cfg_r, cfg_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [SW-1:0]            ws_r, ws_nxt;
  logic [SW-1:0]            os_r, os_nxt;
  logic [SW-1:0]            p_r, p_nxt;
  logic signed [DATA_W-1:0] cur_val_r, cur_val_nxt;
  logic [SW-1:0]            cur_slot_r, cur_slot_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  logic [SW-1:0]            best_slot_r, best_slot_nxt;
  logic [SW-1:0]            best_pos_r, best_pos_nxt;
  logic                     rmv_r, rmv_nxt;
  logic                     moved_r, moved_nxt;

  logic [CW-1:0]            win;
  logic                     clr;
  logic [CW-1:0]            cnt_e;
  logic [SW-1:0]            ws_e, os_e, last;
  logic signed [DATA_W-1:0] rd_val;
  logic [SW-1:0]            rd_slot;
  logic [SW-1:0]            q;
  logic [CXW-1:0]           c_l, c_r;

  always_comb begin
    if (cfg_r == '0) begin
      win = CW'(1);
    end else if (32'(cfg_r) > 32'(WINDOW_MAX)) begin
      win = CW'(WINDOW_MAX);
    end else begin
      win = CW'(cfg_r);
    end
  end

  assign rd_val  = signed'(h_rdata[DATA_W+SW-1:SW]);
  assign rd_slot = h_rdata[SW-1:0];
  assign q       = SW'((p_r - SW'(1)) >> 1);
  assign c_l     = (CXW'(p_r) << 1) | CXW'(1);
  assign c_r     = c_l + CXW'(1);
  assign last    = SW'(cnt_r - CW'(1));

  // Clear on start flag or a full heap; wrap ring pointers past the window.
  assign clr   = in_start || (cnt_r >= win);
  assign cnt_e = clr ? '0 : cnt_r;
  assign ws_e  = (clr || CXW'(ws_r) >= CXW'(win)) ? '0 : ws_r;
  assign os_e  = (clr || CXW'(os_r) >= CXW'(win)) ? '0 : os_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    cnt_nxt       = cnt_r;
    ws_nxt        = ws_r;
    os_nxt        = os_r;
    p_nxt         = p_r;
    cur_val_nxt   = cur_val_r;
    cur_slot_nxt  = cur_slot_r;
    best_val_nxt  = best_val_r;
    best_slot_nxt = best_slot_r;
    best_pos_nxt  = best_pos_r;
    rmv_nxt       = rmv_r;
    moved_nxt     = moved_r;
    h_we          = 1'b0;
    h_waddr       = p_r;
    h_wdata       = {cur_val_r, cur_slot_r};
    h_re          = 1'b0;
    h_raddr       = '0;
    p_we          = 1'b0;
    p_waddr       = cur_slot_r;
    p_wdata       = p_r;
    p_re          = 1'b0;
    p_raddr       = os_r;
    res.load      = 1'b0;
    res.value     = rd_val;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_val_nxt  = in_sample;
          cur_slot_nxt = ws_e;
          p_nxt        = SW'(cnt_e);
          cnt_nxt      = cnt_e + CW'(1);
          ws_nxt       = (CXW'(ws_e) + CXW'(1) == CXW'(win)) ? '0 : ws_e + SW'(1);
          os_nxt       = os_e;
          rmv_nxt      = 1'b0;
          moved_nxt    = 1'b0;
          state_nxt    = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (p_r == '0) begin
          state_nxt = (rmv_r && !moved_r) ? S_DN_CHK : S_FIN;
        end else begin
          h_re      = 1'b1;
          h_raddr   = q;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (rd_val <= cur_val_r) begin
          state_nxt = (rmv_r && !moved_r) ? S_DN_CHK : S_FIN;
        end else begin
          // Shift the parent down into the hole.
          h_we      = 1'b1;
          h_wdata   = h_rdata;
          p_we      = 1'b1;
          p_waddr   = rd_slot;
          p_nxt     = q;
          moved_nxt = 1'b1;
          state_nxt = S_UP_CHK;
        end
      end
      S_DN_CHK: begin
        if (c_l >= CXW'(cnt_r)) begin
          state_nxt = S_FIN;
        end else begin
          h_re      = 1'b1;
          h_raddr   = SW'(c_l);
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        best_val_nxt  = rd_val;
        best_slot_nxt = rd_slot;
        best_pos_nxt  = SW'(c_l);
        if (c_r < CXW'(cnt_r)) begin
          h_re      = 1'b1;
          h_raddr   = SW'(c_r);
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        if (rd_val < best_val_r) begin
          best_val_nxt  = rd_val;
          best_slot_nxt = rd_slot;
          best_pos_nxt  = SW'(c_r);
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (cur_val_r <= best_val_r) begin
          state_nxt = S_FIN;
        end else begin
          // Pull the smaller child up into the hole.
          h_we      = 1'b1;
          h_wdata   = {best_val_r, best_slot_r};
          p_we      = 1'b1;
          p_waddr   = best_slot_r;
          p_nxt     = best_pos_r;
          state_nxt = S_DN_CHK;
        end
      end
      S_FIN: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (rmv_r || cnt_r < win) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        h_re      = 1'b1;
        h_raddr   = '0;
        state_nxt = S_TOP_CAP;
      end
      S_TOP_CAP: begin
        // Hold until the output register frees up.
        if (res_ready) begin
          res.load  = 1'b1;
          state_nxt = S_RM_RD;
        end
      end
      S_RM_RD: begin
        p_re      = 1'b1;
        p_raddr   = os_r;
        os_nxt    = (CXW'(os_r) + CXW'(1) == CXW'(win)) ? '0 : os_r + SW'(1);
        state_nxt = S_RM_LAST;
      end
      S_RM_LAST: begin
        p_nxt     = (p_rdata > last) ? last : p_rdata;
        h_re      = 1'b1;
        h_raddr   = last;
        state_nxt = S_RM_GET;
      end
      S_RM_GET: begin
        // Move the last entry into the removed place and resift it, unless the removed place is the last one.
        cur_val_nxt  = rd_val;
        cur_slot_nxt = rd_slot;
        cnt_nxt      = cnt_r - CW'(1);
        rmv_nxt      = 1'b1;
        moved_nxt    = 1'b0;
        state_nxt    = (p_r == last) ? S_IDLE : S_UP_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      cfg_nxt = cfg_data;
      cnt_nxt = '0;
      ws_nxt  = '0;
      os_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r   <= CFG_W'(1);
      cnt_r   <= '0;
      ws_r    <= '0;
      os_r    <= '0;
      rmv_r   <= 1'b0;
      moved_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cfg_r   <= cfg_nxt;
      cnt_r   <= cnt_nxt;
      ws_r    <= ws_nxt;
      os_r    <= os_nxt;
      rmv_r   <= rmv_nxt;
      moved_r <= moved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    cur_val_r   <= cur_val_nxt;
    cur_slot_r  <= cur_slot_nxt;
    best_val_r  <= best_val_nxt;
    best_slot_r <= best_slot_nxt;
    best_pos_r  <= best_pos_nxt;
  end

endmodule

// ===== rtl/sliding_window_minimum_core.sv =====
// Top level of the sliding window minimum block.
//
// Channel   Dir  Ports                         Payload
// in_       in   in_tvalid/in_tready           tdata: sample[31:0]; tuser: start_of_sequence
// out_      out  out_tvalid/out_tready         tdata: window_min[31:0]
// cfg_      in   cfg_wr_en                     cfg_wr_data: window_size[10:0]
//
// Each sample is inserted by a sift-up; when it reports, the top is read and the entry
// that leaves the window is removed and resifted. Each sift-up or sift-down level is one
// read-compare-write on the heap RAM.
// Reset is synchronous and active low and needs no clearing pass.
// in_tready is high only while the sequencer is idle; a stalled result waits in the
// output register while the removal runs on.
`timescale 1ns / 1ps
module sliding_window_minimum_core #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [swm_pkg::DATA_W-1:0]   in_tdata,   // [31:0] sample
  input  logic                         in_tuser,   // [0] start_of_sequence
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swm_pkg::DATA_W-1:0]   out_tdata,  // [31:0] window_min
  input  logic                         cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data
);
  import swm_pkg::*;

  localparam int SW = $clog2(WINDOW_MAX);
  localparam int HW = DATA_W + SW;

  logic          h_we, h_re, p_we, p_re;
  logic [SW-1:0] h_waddr, h_raddr, p_waddr, p_raddr, p_wdata, p_rdata;
  logic [HW-1:0] h_wdata, h_rdata;
  swm_res_t      res;
  logic          res_ready;

  // Heap entries carry the sample value next to its ring slot.
  swm_ram #(.WIDTH(HW), .DEPTH(WINDOW_MAX)) u_heap (
    .clk(clk), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
    .rd_en(h_re), .rd_addr(h_raddr), .rd_data(h_rdata)
  );

  swm_ram #(.WIDTH(SW), .DEPTH(WINDOW_MAX)) u_place (
    .clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
    .rd_en(p_re), .rd_addr(p_raddr), .rd_data(p_rdata)
  );

  swm_seq #(.WINDOW_MAX(WINDOW_MAX)) u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_sample(signed'(in_tdata)), .in_start(in_tuser),
    .cfg_we(cfg_wr_en), .cfg_data(cfg_wr_data),
    .h_we(h_we), .h_waddr(h_waddr), .h_wdata(h_wdata),
    .h_re(h_re), .h_raddr(h_raddr), .h_rdata(h_rdata),
    .p_we(p_we), .p_waddr(p_waddr), .p_wdata(p_wdata),
    .p_re(p_re), .p_raddr(p_raddr), .p_rdata(p_rdata),
    .res(res), .res_ready(res_ready)
  );

  swm_out u_out (
    .clk(clk), .rst_n(rst_n), .res(res), .res_ready(res_ready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

// ===== rtl/swm_checker.sv =====
// Port-level checker for the sliding window minimum block, bound to the top level.
`timescale 1ns / 1ps
module swm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [swm_pkg::DATA_W-1:0] out_tdata
);

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  // A taken sample makes the sequencer busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accepting a sample");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

endmodule

bind sliding_window_minimum_core swm_checker u_swm_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
